// ===== hw/rtl/tfps_pkg.sv =====
// ----------------------------------------------------------------------------
// tfps_pkg: shared types and constants of the TCP flow packet sequencer
// Field widths, flow table layout, result codes and register indexes.
// ----------------------------------------------------------------------------
package tfps_pkg;

  localparam int MAX_FLOWS = 256;
  localparam int FLOW_W    = $clog2(MAX_FLOWS);
  localparam int NFLOW_W   = FLOW_W + 1;

  localparam int KIND_W      = 1;
  localparam int RAND_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int IDX_OUT_W   = 8;
  localparam int PTYPE_W     = 2;
  localparam int PORT_W      = 16;
  localparam int FLOW_TOT_W  = 9;
  localparam int LEN_W       = 16;
  localparam int LIMIT_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [PORT_W-1:0] PORT_MOD = 16'hFFFF;
  localparam logic [LEN_W-1:0]  MIN_LEN  = 16'd3;

  localparam int DIV_W     = RAND_W - 2;
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [KIND_W-1:0] KIND_PULL    = 1'b0;
  localparam logic [KIND_W-1:0] KIND_RESTART = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_SENT = 2'd0,
    ST_NONE = 2'd1,
    ST_DONE = 2'd2
  } status_t;

  typedef enum logic [PTYPE_W-1:0] {
    PT_SYN  = 2'd0,
    PT_DATA = 2'd1,
    PT_FIN  = 2'd2
  } ptype_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOW_TOTAL   = 3'd0,
    CFG_FLOW_LENGTH  = 3'd1,
    CFG_LIMIT_ENABLE = 3'd2,
    CFG_PACKET_LIMIT = 3'd3,
    CFG_GEN_ACTIVE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0]  progress;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
  } flow_entry_t;

  localparam int ENTRY_W = $bits(flow_entry_t);

endpackage

// ===== hw/rtl/tfps_if.sv =====
// ----------------------------------------------------------------------------
// tfps_if: channel interfaces of the TCP flow packet sequencer
// Pull channel, result channel and register write channel, valid/ready each.
// ----------------------------------------------------------------------------
interface tfps_in_if;
  import tfps_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [RAND_W-1:0]   flow_random;
  logic [RAND_W-1:0]   source_port_random;
  logic [RAND_W-1:0]   dest_port_random;

  modport source (output valid, kind, flow_random, source_port_random, dest_port_random,
                  input ready);
  modport sink (input valid, kind, flow_random, source_port_random, dest_port_random,
                output ready);
endinterface

interface tfps_out_if;
  import tfps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [IDX_OUT_W-1:0]  flow_index;
  logic [PTYPE_W-1:0]    packet_type;
  logic [PORT_W-1:0]     source_port;
  logic [PORT_W-1:0]     dest_port;

  modport source (output valid, status, flow_index, packet_type, source_port, dest_port,
                  input ready);
  modport sink (input valid, status, flow_index, packet_type, source_port, dest_port,
                output ready);
endinterface

interface tfps_cfg_if;
  import tfps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tcp_flow_packet_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// tcp_flow_packet_sequencer_top: picks the next packet of a TCP flow generator
// Each pull beat yields one result beat naming flow, packet type and ports.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   pull beats: kind 0 asks for one packet slot, kind 1 clears the
//           sent count and the drain-done flag and returns no result.
//   out_ch  one result beat per pull: status, flow, packet type, ports.
//   cfg_ch  register writes, always ready; write only while the block idles.
// Timing:
//   A restart beat is taken in S_IDLE and leaves the block idle. A pull with
//   the generator off or the drain done goes by S_EMIT to the output register.
//   A random pull passes S_DIV, whose remainder unit resolves two dividend
//   bits per cycle, then S_RD, S_UPD (flow table read, write-back) and S_EMIT.
//   A drain pull walks the flow table through S_SCAN_RD and S_SCAN_CHK per flow.
//   One item is in work at a time; the next pull is taken once the result is
//   in the output register.
// Reset: control and config registers take their defaults; the flow table is
//   cleared at once through per-entry valid bits, so no clearing pass is needed.
// Stall: the output register holds one result while the next pull is worked
//   on; a further result waits inside the block until the register frees up.
// ----------------------------------------------------------------------------
module tcp_flow_packet_sequencer_top (
  input logic         clk,
  input logic         rst_n,
  tfps_in_if.sink     in_ch,
  tfps_out_if.source  out_ch,
  tfps_cfg_if.sink    cfg_ch
);
  import tfps_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DIV      = 7'b0000010,
    S_RD       = 7'b0000100,
    S_UPD      = 7'b0001000,
    S_SCAN_RD  = 7'b0010000,
    S_SCAN_CHK = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  function automatic logic [PORT_W-1:0] port_mod(input logic [RAND_W-1:0] r);
    logic [PORT_W:0] s;
    begin
      s = (PORT_W+1)'(r[RAND_W-1:PORT_W+2]) + (PORT_W+1)'(r[PORT_W+1:2]);
      if (s >= (PORT_W+1)'(PORT_MOD)) begin
        s = s - (PORT_W+1)'(PORT_MOD);
      end
      port_mod = s[PORT_W-1:0];
    end
  endfunction

  state_t state_r, state_nxt;

  logic [FLOW_TOT_W-1:0] flow_total_r, flow_total_nxt;
  logic [LEN_W-1:0]      flow_length_r, flow_length_nxt;
  logic                  limit_en_r, limit_en_nxt;
  logic [LIMIT_W-1:0]    packet_limit_r, packet_limit_nxt;
  logic                  gen_active_r, gen_active_nxt;

  logic [LIMIT_W-1:0]    sent_total_r, sent_total_nxt;
  logic                  all_fins_r, all_fins_nxt;
  logic [MAX_FLOWS-1:0]  flow_vld_r;
  logic                  rd_vld_r, rd_vld_nxt;

  logic [NFLOW_W-1:0]    div_rem_r, div_rem_nxt, div_rem_step;
  logic [DIV_W-1:0]      div_q_r, div_q_nxt, div_q_step;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;

  logic [FLOW_W-1:0]     flow_idx_r, flow_idx_nxt;
  logic [PORT_W-1:0]     sport_r, sport_nxt;
  logic [PORT_W-1:0]     dport_r, dport_nxt;

  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [IDX_OUT_W-1:0]  res_idx_r, res_idx_nxt;
  logic [PTYPE_W-1:0]    res_type_r, res_type_nxt;
  logic [PORT_W-1:0]     res_sport_r, res_sport_nxt;
  logic [PORT_W-1:0]     res_dport_r, res_dport_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [IDX_OUT_W-1:0]  out_idx_r, out_idx_nxt;
  logic [PTYPE_W-1:0]    out_type_r, out_type_nxt;
  logic [PORT_W-1:0]     out_sport_r, out_sport_nxt;
  logic [PORT_W-1:0]     out_dport_r, out_dport_nxt;

  logic                  ram_we, ram_re;
  logic [FLOW_W-1:0]     ram_waddr, ram_raddr;
  flow_entry_t           ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  flow_entry_t           cur_entry, upd_entry;
  logic [LEN_W-1:0]      upd_base, upd_cnt;

  logic [NFLOW_W-1:0]    n_used;
  logic [LEN_W-1:0]      len_used;
  logic                  limit_hit;
  logic [LIMIT_W-1:0]    sent_inc;
  logic                  in_fire, out_free, clear_cnt;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign clear_cnt    = in_fire && (in_ch.kind == KIND_RESTART);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.flow_index  = out_idx_r;
  assign out_ch.packet_type = out_type_r;
  assign out_ch.source_port = out_sport_r;
  assign out_ch.dest_port   = out_dport_r;

  always_comb begin
    if (flow_total_r == '0) begin
      n_used = NFLOW_W'(1);
    end else if (32'(flow_total_r) > 32'(MAX_FLOWS)) begin
      n_used = NFLOW_W'(MAX_FLOWS);
    end else begin
      n_used = NFLOW_W'(flow_total_r);
    end
  end

  assign len_used  = (flow_length_r < MIN_LEN) ? MIN_LEN : flow_length_r;
  assign limit_hit = limit_en_r && (sent_total_r >= packet_limit_r);
  assign sent_inc  = (sent_total_r == '1) ? sent_total_r : sent_total_r + LIMIT_W'(1);

  // remainder unit: two dividend bits per cycle
  always_comb begin
    div_rem_step = div_rem_r;
    div_q_step   = div_q_r;
    for (int b = 0; b < DIV_BITS; b++) begin
      div_rem_step = {div_rem_step[NFLOW_W-2:0], div_q_step[DIV_W-1]};
      div_q_step   = {div_q_step[DIV_W-2:0], 1'b0};
      if (div_rem_step >= n_used) begin
        div_rem_step = div_rem_step - n_used;
      end
    end
  end

  assign cur_entry = rd_vld_r ? flow_entry_t'(ram_rdata) : '0;

  always_comb begin
    upd_entry = cur_entry;
    if (cur_entry.progress == len_used) begin
      upd_entry.sport = sport_r;
      upd_entry.dport = dport_r;
      upd_base        = '0;
    end else begin
      upd_base = cur_entry.progress;
    end
    upd_cnt            = upd_base + LEN_W'(1);
    upd_entry.progress = upd_cnt;
  end

  always_comb begin
    flow_total_nxt   = flow_total_r;
    flow_length_nxt  = flow_length_r;
    limit_en_nxt     = limit_en_r;
    packet_limit_nxt = packet_limit_r;
    gen_active_nxt   = gen_active_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_FLOW_TOTAL:   flow_total_nxt   = cfg_ch.data[FLOW_TOT_W-1:0];
        CFG_FLOW_LENGTH:  flow_length_nxt  = cfg_ch.data[LEN_W-1:0];
        CFG_LIMIT_ENABLE: limit_en_nxt     = cfg_ch.data[0];
        CFG_PACKET_LIMIT: packet_limit_nxt = cfg_ch.data[LIMIT_W-1:0];
        CFG_GEN_ACTIVE:   gen_active_nxt   = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    sent_total_nxt = sent_total_r;
    all_fins_nxt   = all_fins_r;
    div_rem_nxt    = div_rem_r;
    div_q_nxt      = div_q_r;
    div_cnt_nxt    = div_cnt_r;
    flow_idx_nxt   = flow_idx_r;
    sport_nxt      = sport_r;
    dport_nxt      = dport_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_type_nxt   = res_type_r;
    res_sport_nxt  = res_sport_r;
    res_dport_nxt  = res_dport_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_type_nxt   = out_type_r;
    out_sport_nxt  = out_sport_r;
    out_dport_nxt  = out_dport_r;
    ram_we         = 1'b0;
    ram_waddr      = flow_idx_r;
    ram_wdata      = upd_entry;
    ram_re         = 1'b0;
    ram_raddr      = flow_idx_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_idx_nxt   = '0;
          res_type_nxt  = PT_SYN;
          res_sport_nxt = '0;
          res_dport_nxt = '0;
          if (in_ch.kind == KIND_RESTART) begin
            sent_total_nxt = '0;
            all_fins_nxt   = 1'b0;
          end else if (!gen_active_r) begin
            res_status_nxt = ST_NONE;
            state_nxt      = S_EMIT;
          end else if (limit_hit) begin
            if (all_fins_r) begin
              res_status_nxt = ST_DONE;
              state_nxt      = S_EMIT;
            end else begin
              flow_idx_nxt = '0;
              state_nxt    = S_SCAN_RD;
            end
          end else begin
            div_rem_nxt = '0;
            div_q_nxt   = in_ch.flow_random[RAND_W-1:2];
            div_cnt_nxt = '0;
            sport_nxt   = port_mod(in_ch.source_port_random);
            dport_nxt   = port_mod(in_ch.dest_port_random);
            state_nxt   = S_DIV;
          end
        end
      end
      S_DIV: begin
        div_rem_nxt = div_rem_step;
        div_q_nxt   = div_q_step;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ram_re       = 1'b1;
        ram_raddr    = div_rem_r[FLOW_W-1:0];
        flow_idx_nxt = div_rem_r[FLOW_W-1:0];
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        ram_we         = 1'b1;
        ram_wdata      = upd_entry;
        sent_total_nxt = sent_inc;
        res_status_nxt = ST_SENT;
        res_idx_nxt    = IDX_OUT_W'(flow_idx_r);
        res_sport_nxt  = upd_entry.sport;
        res_dport_nxt  = upd_entry.dport;
        if (upd_cnt == LEN_W'(1)) begin
          res_type_nxt = PT_SYN;
        end else if (upd_cnt == len_used) begin
          res_type_nxt = PT_FIN;
        end else begin
          res_type_nxt = PT_DATA;
        end
        state_nxt = S_EMIT;
      end
      S_SCAN_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (cur_entry.progress != len_used) begin
          ram_we             = 1'b1;
          ram_wdata          = cur_entry;
          ram_wdata.progress = len_used;
          sent_total_nxt     = sent_inc;
          res_status_nxt     = ST_SENT;
          res_idx_nxt        = IDX_OUT_W'(flow_idx_r);
          res_type_nxt       = PT_FIN;
          res_sport_nxt      = cur_entry.sport;
          res_dport_nxt      = cur_entry.dport;
          state_nxt          = S_EMIT;
        end else if (NFLOW_W'(flow_idx_r) == n_used - NFLOW_W'(1)) begin
          all_fins_nxt   = 1'b1;
          res_status_nxt = ST_DONE;
          state_nxt      = S_EMIT;
        end else begin
          flow_idx_nxt = flow_idx_r + FLOW_W'(1);
          state_nxt    = S_SCAN_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_type_nxt   = res_type_r;
          out_sport_nxt  = res_sport_r;
          out_dport_nxt  = res_dport_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_vld_nxt = ram_re ? flow_vld_r[ram_raddr] : rd_vld_r;

  tfps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_FLOWS)
  ) u_flow_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      flow_total_r   <= FLOW_TOT_W'(1);
      flow_length_r  <= MIN_LEN;
      limit_en_r     <= 1'b0;
      packet_limit_r <= '0;
      gen_active_r   <= 1'b1;
      sent_total_r   <= '0;
      all_fins_r     <= 1'b0;
      flow_vld_r     <= '0;
      rd_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      flow_total_r   <= flow_total_nxt;
      flow_length_r  <= flow_length_nxt;
      limit_en_r     <= limit_en_nxt;
      packet_limit_r <= packet_limit_nxt;
      gen_active_r   <= gen_active_nxt;
      sent_total_r   <= sent_total_nxt;
      all_fins_r     <= all_fins_nxt;
      rd_vld_r       <= rd_vld_nxt;
      out_valid_r    <= out_valid_nxt;
      if (ram_we) begin
        flow_vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    div_rem_r    <= div_rem_nxt;
    div_q_r      <= div_q_nxt;
    div_cnt_r    <= div_cnt_nxt;
    flow_idx_r   <= flow_idx_nxt;
    sport_r      <= sport_nxt;
    dport_r      <= dport_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_type_r   <= res_type_nxt;
    res_sport_r  <= res_sport_nxt;
    res_dport_r  <= res_dport_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_type_r   <= out_type_nxt;
    out_sport_r  <= out_sport_nxt;
    out_dport_r  <= out_dport_nxt;
  end

  a_no_packet_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_SENT) |->
      (out_idx_r == '0) && (out_type_r == '0) && (out_sport_r == '0) && (out_dport_r == '0))
    else $error("no-packet result carries nonzero fields");

  a_sent_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(clear_cnt) |-> sent_total_r >= $past(sent_total_r))
    else $error("sent count decreased without restart");

  a_div_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) || (state_r == S_RD) |-> div_rem_r < n_used)
    else $error("flow remainder out of range");

  a_written_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> flow_vld_r[$past(ram_waddr)])
    else $error("written flow entry not marked valid");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD) || (state_r == S_SCAN_CHK) |-> NFLOW_W'(flow_idx_r) < n_used)
    else $error("drain scan beyond flows in use");

endmodule

// ===== hw/rtl/tfps_ram.sv =====
// ----------------------------------------------------------------------------
// tfps_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tfps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== tb/sv/tb_tcp_flow_packet_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_flow_packet_sequencer_top: self-checking bench of the flow sequencer
// Drives pull and restart beats with random words, keeps its own copy of the
// flow table, the sent count and the registers, and checks every result beat
// field by field in order. Phases cover reset defaults, port extremes,
// clamped registers, limit draining, an inactive generator and random
// settings, under no idling, a slow sender, a slow receiver and both.
// ----------------------------------------------------------------------------
module tb_tcp_flow_packet_sequencer_top;
  import tfps_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 40;
  localparam logic [RAND_W-1:0] PORT_TOP_WORD = 32'd262136;

  typedef struct packed {
    status_t               status;
    logic [IDX_OUT_W-1:0]  flow;
    ptype_t                ptype;
    logic [PORT_W-1:0]     sport;
    logic [PORT_W-1:0]     dport;
  } packet_t;

  logic clk;
  logic rst_n;

  tfps_in_if  in_ch ();
  tfps_out_if out_ch ();
  tfps_cfg_if cfg_ch ();

  tcp_flow_packet_sequencer_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // flow table and counters as the block should hold them
  logic [LEN_W-1:0]      pkt_count [MAX_FLOWS];
  logic [PORT_W-1:0]     sport_tab [MAX_FLOWS];
  logic [PORT_W-1:0]     dport_tab [MAX_FLOWS];
  logic [LIMIT_W-1:0]    pkt_sent;
  logic                  drain_over;

  logic [FLOW_TOT_W-1:0] n_flows_reg;
  logic [LEN_W-1:0]      len_reg;
  logic                  limit_on_reg;
  logic [LIMIT_W-1:0]    limit_reg;
  logic                  active_reg;

  packet_t packet_q [$];
  bit      failed;
  int      send_idle_pct;
  int      recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  function automatic packet_t pick_packet(input logic [RAND_W-1:0] fr,
                                          input logic [RAND_W-1:0] sr,
                                          input logic [RAND_W-1:0] dr);
    int unsigned n;
    int unsigned len;
    int unsigned idx;
    packet_t     p;
    n = (n_flows_reg == 0) ? 1 : (n_flows_reg > MAX_FLOWS) ? MAX_FLOWS : n_flows_reg;
    len = (len_reg < MIN_LEN) ? MIN_LEN : len_reg;
    p = '0;
    p.status = ST_NONE;
    p.ptype = PT_SYN;
    if (active_reg) begin
      if (limit_on_reg && pkt_sent >= limit_reg) begin
        p.status = ST_DONE;
        if (!drain_over) begin
          idx = 0;
          while (idx < n && pkt_count[idx] == len) idx++;
          if (idx == n) begin
            drain_over = 1'b1;
          end else begin
            pkt_count[idx] = LEN_W'(len);
            p.status = ST_SENT;
            p.ptype = PT_FIN;
          end
        end
      end else begin
        idx = (fr >> 2) % n;
        if (pkt_count[idx] == len) begin
          sport_tab[idx] = PORT_W'((sr >> 2) % PORT_MOD);
          dport_tab[idx] = PORT_W'((dr >> 2) % PORT_MOD);
          pkt_count[idx] = '0;
        end
        pkt_count[idx] = pkt_count[idx] + 1'b1;
        p.status = ST_SENT;
        if (pkt_count[idx] == 1) begin
          p.ptype = PT_SYN;
        end else if (pkt_count[idx] == len) begin
          p.ptype = PT_FIN;
        end else begin
          p.ptype = PT_DATA;
        end
      end
      if (p.status == ST_SENT) begin
        p.flow = IDX_OUT_W'(idx);
        p.sport = sport_tab[idx];
        p.dport = dport_tab[idx];
        if (pkt_sent != '1) pkt_sent = pkt_sent + 1'b1;
      end
    end
    return p;
  endfunction

  task automatic push_beat(input logic [KIND_W-1:0] kind, input logic [RAND_W-1:0] fr,
                           input logic [RAND_W-1:0] sr, input logic [RAND_W-1:0] dr);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid              <= 1'b1;
    in_ch.kind               <= kind;
    in_ch.flow_random        <= fr;
    in_ch.source_port_random <= sr;
    in_ch.dest_port_random   <= dr;
    do @(posedge clk); while (!in_ch.ready);
    if (kind == KIND_RESTART) begin
      pkt_sent = '0;
      drain_over = 1'b0;
    end else begin
      packet_q.push_back(pick_packet(fr, sr, dr));
    end
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (packet_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (sel)
      CFG_FLOW_TOTAL:   n_flows_reg  = value[FLOW_TOT_W-1:0];
      CFG_FLOW_LENGTH:  len_reg      = value[LEN_W-1:0];
      CFG_LIMIT_ENABLE: limit_on_reg = value[0];
      CFG_PACKET_LIMIT: limit_reg    = value[LIMIT_W-1:0];
      CFG_GEN_ACTIVE:   active_reg   = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned flows, input int unsigned len,
                           input bit limit_on, input logic [LIMIT_W-1:0] limit,
                           input bit active);
    wait_quiet();
    cfg_write(CFG_FLOW_TOTAL, flows);
    cfg_write(CFG_FLOW_LENGTH, len);
    cfg_write(CFG_LIMIT_ENABLE, CFG_DATA_W'(limit_on));
    cfg_write(CFG_PACKET_LIMIT, limit);
    cfg_write(CFG_GEN_ACTIVE, CFG_DATA_W'(active));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic run_random(input int count, input int restart_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < restart_pct) begin
        push_beat(KIND_RESTART, $urandom, $urandom, $urandom);
      end else begin
        push_beat(KIND_PULL, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_directed();
    set_idle(0, 0);
    // one flow of three from reset, ports at both ends
    push_beat(KIND_PULL, '0, '0, '0);
    push_beat(KIND_PULL, '1, '1, '1);
    push_beat(KIND_PULL, '0, '0, '0);
    push_beat(KIND_PULL, '1, PORT_TOP_WORD, '1);
    push_beat(KIND_PULL, '0, '0, '0);
    push_beat(KIND_PULL, '1, '1, '1);
    push_beat(KIND_PULL, '0, '1, PORT_TOP_WORD);
    configure(1, 3, 1'b0, '0, 1'b0);
    push_beat(KIND_PULL, '1, '1, '1);
    push_beat(KIND_RESTART, '1, '1, '1);
    // zero flow count and zero length clamp up, an oversized flow count clamps down
    configure(0, 0, 1'b0, '0, 1'b1);
    push_beat(KIND_PULL, '1, '0, '0);
    push_beat(KIND_PULL, '0, '1, '1);
    configure(511, 3, 1'b0, '0, 1'b1);
    push_beat(KIND_PULL, 32'd1020, '0, '1);
    push_beat(KIND_PULL, '1, '1, '0);
    // limit zero: drain the three open flows of four, then done twice, and done again after restart
    configure(4, 3, 1'b1, '0, 1'b1);
    repeat (5) push_beat(KIND_PULL, $urandom, $urandom, $urandom);
    push_beat(KIND_RESTART, '0, '0, '0);
    push_beat(KIND_PULL, '0, '0, '0);
    // drain at full length, then shrink length so the count wraps
    configure(1, 65535, 1'b1, '0, 1'b1);
    push_beat(KIND_RESTART, '0, '0, '0);
    push_beat(KIND_PULL, '0, '0, '0);
    push_beat(KIND_PULL, '0, '0, '0);
    configure(1, 3, 1'b0, '0, 1'b1);
    push_beat(KIND_PULL, '1, '1, '1);
    push_beat(KIND_PULL, '1, '1, '1);
  endtask

  task automatic test_short_flows();
    configure($urandom_range(1, 8), $urandom_range(3, 6), 1'b0, '0, 1'b1);
    set_idle(0, 0);
    run_random(250, 2);
  endtask

  task automatic test_limit_drain();
    configure($urandom_range(1, 32), $urandom_range(3, 10), 1'b1,
              $urandom_range(20, 80), 1'b1);
    set_idle(80, 0);
    run_random(300, 4);
  endtask

  task automatic test_wide_table();
    configure(256, 65535, 1'b1, '1, 1'b1);
    set_idle(0, 80);
    run_random(150, 2);
    configure($urandom_range(257, 511), 65535, 1'b1, '1, 1'b1);
    run_random(150, 2);
  endtask

  task automatic test_clamped_length();
    configure($urandom_range(1, 4), $urandom_range(0, 2), 1'b1,
              $urandom_range(0, 30), 1'b1);
    set_idle(15, 15);
    run_random(300, 5);
  endtask

  task automatic test_generator_off();
    configure($urandom_range(1, 256), $urandom_range(3, 8), 1'b0, '0, 1'b0);
    set_idle(15, 15);
    run_random(50, 10);
  endtask

  task automatic test_full_drain();
    configure(256, 3, 1'b1, '0, 1'b1);
    set_idle(0, 0);
    push_beat(KIND_RESTART, $urandom, $urandom, $urandom);
    run_random(260, 0);
  endtask

  task automatic test_random_config();
    configure($urandom_range(0, 511),
              ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(3, 12),
              1'b1, $urandom_range(0, 400), 1'b1);
    set_idle(80, 0);
    run_random(125, 3);
    configure($urandom_range(1, 64), $urandom_range(3, 12), 1'($urandom_range(1)),
              $urandom_range(50, 300), 1'b1);
    set_idle(0, 80);
    run_random(125, 3);
  endtask

  always @(posedge clk) begin : packet_monitor
    packet_t got;
    packet_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = status_t'(out_ch.status);
      got.flow   = out_ch.flow_index;
      got.ptype  = ptype_t'(out_ch.packet_type);
      got.sport  = out_ch.source_port;
      got.dport  = out_ch.dest_port;
      if (packet_q.size() == 0) begin
        $error("result beat with no pull pending: status %0d flow %0d", got.status, got.flow);
        failed = 1'b1;
      end else begin
        want = packet_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          failed = 1'b1;
        end
        if (got.flow !== want.flow) begin
          $error("flow_index: expected %0d, got %0d", want.flow, got.flow);
          failed = 1'b1;
        end
        if (got.ptype !== want.ptype) begin
          $error("packet_type: expected %0d, got %0d", want.ptype, got.ptype);
          failed = 1'b1;
        end
        if (got.sport !== want.sport) begin
          $error("source_port: expected %0d, got %0d", want.sport, got.sport);
          failed = 1'b1;
        end
        if (got.dport !== want.dport) begin
          $error("dest_port: expected %0d, got %0d", want.dport, got.dport);
          failed = 1'b1;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < MAX_FLOWS; i++) begin
      pkt_count[i] = '0;
      sport_tab[i] = '0;
      dport_tab[i] = '0;
    end
    pkt_sent = '0;
    drain_over = 1'b0;
    n_flows_reg = 9'd1;
    len_reg = 16'd3;
    limit_on_reg = 1'b0;
    limit_reg = '0;
    active_reg = 1'b1;

    rst_n                    <= 1'b0;
    in_ch.valid              <= 1'b0;
    in_ch.kind               <= KIND_PULL;
    in_ch.flow_random        <= '0;
    in_ch.source_port_random <= '0;
    in_ch.dest_port_random   <= '0;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.index             <= CFG_FLOW_TOTAL;
    cfg_ch.data              <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_short_flows();
    test_limit_drain();
    test_wide_table();
    test_clamped_length();
    test_generator_off();
    test_full_drain();
    test_random_config();

    wait_quiet();
    repeat (END_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
